// ===== rtl/core/skf_pkg.sv =====
// Shared types and constants for the scalar Kalman filter.
// No dependencies; compiled first.
package skf_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned CSR_IDX_W = 8;
   localparam int unsigned DIV_STEPS = 32;
   localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

   localparam logic [DATA_W-1:0] DEF_PROCESS_NOISE = 32'd17;
   localparam logic [DATA_W-1:0] DEF_MEAS_NOISE    = 32'd16777;
   localparam logic [DATA_W-1:0] DEF_INIT_VARIANCE = 32'd16777216;
   localparam logic [DATA_W-1:0] DEF_INIT_ESTIMATE = 32'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_NOISE       = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_ESTIMATE = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_VARIANCE = 8'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_MUL_EST,
      ST_MUL_VAR,
      ST_DONE
   } skf_state_type;

   // effective configuration, defaults already substituted
   typedef struct packed {
      logic [DATA_W-1:0]        process_noise;
      logic [DATA_W-1:0]        measurement_noise;
      logic signed [DATA_W-1:0] initial_estimate;
      logic [DATA_W-1:0]        initial_variance;
   } skf_cfg_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic prep;
      logic div_step;
      logic mul_est;
      logic mul_var;
      logic commit;
   } skf_cmd_type;

endpackage

// ===== rtl/core/skf_req_if.sv =====
// Input channel: measurement transactions.
// Depends on skf_pkg.
interface skf_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [skf_pkg::DATA_W-1:0]   measurement;
   logic                                restart;

   modport source (output valid, output measurement, output restart, input ready);
   modport sink   (input valid, input measurement, input restart, output ready);
endinterface

// ===== rtl/core/skf_rsp_if.sv =====
// Result channel: updated estimate and variance transactions.
// Depends on skf_pkg.
interface skf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [skf_pkg::DATA_W-1:0]   estimate;
   logic [skf_pkg::DATA_W-1:0]          variance;

   modport source (output valid, output estimate, output variance, input ready);
   modport sink   (input valid, input estimate, input variance, output ready);
endinterface

// ===== rtl/core/skf_csr_if.sv =====
// Configuration write channel: register index and write data.
// Depends on skf_pkg.
interface skf_csr_if;
   logic                              valid;
   logic                              ready;
   logic [skf_pkg::CSR_IDX_W-1:0]     index;
   logic [skf_pkg::DATA_W-1:0]        data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/skf_csr.sv =====
// Configuration registers with default substitution for zero values.
// Depends on skf_pkg.
module skf_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_valid,
   input  logic [skf_pkg::CSR_IDX_W-1:0] wr_index,
   input  logic [skf_pkg::DATA_W-1:0]    wr_data,
   output skf_pkg::skf_cfg_type          cfg
);
   import skf_pkg::*;

   logic [DATA_W-1:0] pn_ff, mn_ff, ie_ff, iv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pn_ff <= DEF_PROCESS_NOISE;
         mn_ff <= DEF_MEAS_NOISE;
         ie_ff <= DEF_INIT_ESTIMATE;
         iv_ff <= DEF_INIT_VARIANCE;
      end else if (wr_valid) begin
         unique case (wr_index)
            CSR_PROCESS_NOISE:    pn_ff <= wr_data;
            CSR_MEAS_NOISE:       mn_ff <= wr_data;
            CSR_INITIAL_ESTIMATE: ie_ff <= wr_data;
            CSR_INITIAL_VARIANCE: iv_ff <= wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.process_noise     = (pn_ff == '0) ? DEF_PROCESS_NOISE : pn_ff;
      cfg.measurement_noise = (mn_ff == '0) ? DEF_MEAS_NOISE : mn_ff;
      cfg.initial_estimate  = ie_ff;
      cfg.initial_variance  = (iv_ff == '0) ? DEF_INIT_VARIANCE : iv_ff;
   end

endmodule

// ===== rtl/core/skf_ctrl.sv =====
// Sequencing state machine: prep, 32 divider steps, two multiplies, commit.
// Depends on skf_pkg.
module skf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output skf_pkg::skf_cmd_type  cmd
);
   import skf_pkg::*;

   skf_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_MUL_EST;
            end
         end
         ST_MUL_EST: begin
            cmd.mul_est = 1'b1;
            state_in    = ST_MUL_VAR;
         end
         ST_MUL_VAR: begin
            cmd.mul_var = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/skf_dp.sv =====
// Datapath: filter state, restoring gain divider, shared 32x32 multiplier,
// output registers. Depends on skf_pkg.
module skf_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  skf_pkg::skf_cmd_type               cmd,
   input  skf_pkg::skf_cfg_type               cfg,
   input  logic signed [skf_pkg::DATA_W-1:0]  req_measurement,
   input  logic                               req_restart,
   output logic signed [skf_pkg::DATA_W-1:0]  rsp_estimate,
   output logic [skf_pkg::DATA_W-1:0]         rsp_variance
);
   import skf_pkg::*;

   logic signed [DATA_W-1:0] est_ff;
   logic [DATA_W-1:0]        var_ff;
   logic signed [DATA_W-1:0] meas_ff;
   logic [DATA_W-1:0]        prior_ff;
   logic [DATA_W:0]          s_ff;
   logic [DATA_W:0]          rem_ff;
   logic [DATA_W-1:0]        k_ff;
   logic [DATA_W-1:0]        mag_ff;
   logic                     neg_ff;
   logic [2*DATA_W-1:0]      prod_ff;
   logic signed [DATA_W-1:0] est_new_ff;
   logic signed [DATA_W-1:0] rsp_est_ff;
   logic [DATA_W-1:0]        rsp_var_ff;

   logic [DATA_W:0]          prior_sum;
   logic [DATA_W-1:0]        prior_sat;
   logic [DATA_W:0]          diff, diff_neg;
   logic [DATA_W+1:0]        rem_sh, rem_sub;
   logic [DATA_W-1:0]        mul_a, mul_b;
   logic [2*DATA_W-1:0]      prod_rnd;
   logic [DATA_W-1:0]        rnd_hi;
   logic [DATA_W-1:0]        one_minus_k;

   assign prior_sum   = {1'b0, var_ff} + {1'b0, cfg.process_noise};
   assign prior_sat   = prior_sum[DATA_W] ? '1 : prior_sum[DATA_W-1:0];
   assign diff        = {meas_ff[DATA_W-1], meas_ff} - {est_ff[DATA_W-1], est_ff};
   assign diff_neg    = '0 - diff;
   assign rem_sh      = {rem_ff, 1'b0};
   assign rem_sub     = rem_sh - {1'b0, s_ff};
   assign one_minus_k = '0 - k_ff;
   assign mul_a       = cmd.mul_est ? k_ff : one_minus_k;
   assign mul_b       = cmd.mul_est ? mag_ff : prior_ff;
   assign prod_rnd    = prod_ff + (2*DATA_W)'(64'h8000_0000);
   assign rnd_hi      = prod_rnd[2*DATA_W-1:DATA_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff <= DEF_INIT_ESTIMATE;
         var_ff <= DEF_INIT_VARIANCE;
      end else if (cmd.load && req_restart) begin
         est_ff <= cfg.initial_estimate;
         var_ff <= cfg.initial_variance;
      end else if (cmd.commit) begin
         est_ff <= est_new_ff;
         var_ff <= rnd_hi;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         meas_ff <= req_measurement;
      end
      if (cmd.prep) begin
         prior_ff <= prior_sat;
         s_ff     <= {1'b0, prior_sat} + {1'b0, cfg.measurement_noise};
         rem_ff   <= {1'b0, prior_sat};
         neg_ff   <= diff[DATA_W];
         mag_ff   <= diff[DATA_W] ? diff_neg[DATA_W-1:0] : diff[DATA_W-1:0];
      end
      if (cmd.div_step) begin
         // restoring step: remainder stays below the divisor
         if (!rem_sub[DATA_W+1]) begin
            rem_ff <= rem_sub[DATA_W:0];
            k_ff   <= {k_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[DATA_W:0];
            k_ff   <= {k_ff[DATA_W-2:0], 1'b0};
         end
      end
      if (cmd.mul_est || cmd.mul_var) begin
         prod_ff <= (2*DATA_W)'(mul_a) * (2*DATA_W)'(mul_b);
      end
      if (cmd.mul_var) begin
         est_new_ff <= neg_ff ? est_ff - $signed(rnd_hi) : est_ff + $signed(rnd_hi);
      end
      if (cmd.commit) begin
         rsp_est_ff <= est_new_ff;
         rsp_var_ff <= rnd_hi;
      end
   end

   assign rsp_estimate = rsp_est_ff;
   assign rsp_variance = rsp_var_ff;

endmodule

// ===== rtl/core/scalar_kalman_filter_top.sv =====
// Scalar random-walk Kalman filter, top level.
// Channels req_ch (measurement, restart), rsp_ch (estimate, variance) and
// csr_ch (register index, write data). Register 0 process noise, 1
// measurement noise, 2 initial estimate, 3 initial variance; other indices
// are accepted and ignored. csr_ch.ready is always high.
// Each measurement gives one result. After the request transaction the block
// runs a prep state, the restoring gain divider (one quotient bit per cycle),
// the estimate and variance multiplies on the shared 32x32 multiplier and a
// commit state that registers the result. req_ch.ready is high only between
// items, so a new request is taken only after the previous one is committed.
// The result sits in an output register; the next request is taken while it
// waits. If the receiver still stalls when the next result is ready, the
// block holds in its commit state until the output register frees.
// Synchronous reset loads the register defaults and sets the estimate to 0
// and the variance to 1.0. Depends on skf_pkg and the channel interfaces.
module scalar_kalman_filter_top (
   input  logic  clock,
   input  logic  reset,
   skf_req_if.sink   req_ch,
   skf_rsp_if.source rsp_ch,
   skf_csr_if.sink   csr_ch
);
   import skf_pkg::*;

   skf_cfg_type cfg;
   skf_cmd_type cmd;

   assign csr_ch.ready = 1'b1;

   skf_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   skf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   skf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg),
      .req_measurement (req_ch.measurement),
      .req_restart     (req_ch.restart),
      .rsp_estimate    (rsp_ch.estimate),
      .rsp_variance    (rsp_ch.variance)
   );

endmodule

// ===== rtl/core/skf_chk.sv =====
// Port-level checks for the Kalman filter top level, bound to it below.
// Depends on skf_pkg.
module skf_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [skf_pkg::DATA_W-1:0] rsp_estimate,
   input logic [skf_pkg::DATA_W-1:0]        rsp_variance
);
   import skf_pkg::*;

   logic req_acc;
   assign req_acc = req_valid && req_ready;

   // one item at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("request taken while an item is in flight");

   // a result never appears straight after its request
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_acc))
      else $error("result raised in the cycle after a request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_estimate) && $stable(rsp_variance))
      else $error("stalled result dropped or changed");

endmodule

bind scalar_kalman_filter_top skf_chk u_skf_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_estimate (rsp_ch.estimate),
   .rsp_variance (rsp_ch.variance)
);
